[hdl/dlv_pkg.sv]
// Shared types and constants for the lag-one velocity estimator.
// Used by the controller, datapath and top level.
package dlv_pkg;
	localparam int ACC_W = 48;
	localparam int CORDIC_STEPS = 30;

	typedef struct packed {
		logic take;       // sample word accepted
		logic accum;      // accumulate current sample
		logic clear;      // clear sums after capture
		logic start;      // latch sums and start finish unit
	} dlv_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dlv_sts_t;

	function automatic logic [31:0] turn_angle(input logic [4:0] i);
		logic [31:0] t;
		begin
			case (i)
				5'd0: t = 32'd536870912;
				5'd1: t = 32'd316933406;
				5'd2: t = 32'd167458907;
				5'd3: t = 32'd85004756;
				5'd4: t = 32'd42667331;
				5'd5: t = 32'd21354465;
				5'd6: t = 32'd10679838;
				5'd7: t = 32'd5340245;
				5'd8: t = 32'd2670163;
				5'd9: t = 32'd1335087;
				5'd10: t = 32'd667544;
				5'd11: t = 32'd333772;
				5'd12: t = 32'd166886;
				5'd13: t = 32'd83443;
				5'd14: t = 32'd41722;
				5'd15: t = 32'd20861;
				5'd16: t = 32'd10430;
				5'd17: t = 32'd5215;
				5'd18: t = 32'd2608;
				5'd19: t = 32'd1304;
				5'd20: t = 32'd652;
				5'd21: t = 32'd326;
				5'd22: t = 32'd163;
				5'd23: t = 32'd81;
				5'd24: t = 32'd41;
				5'd25: t = 32'd20;
				5'd26: t = 32'd10;
				5'd27: t = 32'd5;
				5'd28: t = 32'd3;
				5'd29: t = 32'd1;
				default: t = 32'd0;
			endcase
			return t;
		end
	endfunction
endpackage

[hdl/dlv_datapath.sv]
// Datapath: accumulators, iterative CORDIC, normalize, square root and divide.
// Depends on dlv_pkg; driven by dlv_ctrl.
module dlv_datapath #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  dlv_pkg::dlv_cmd_t cmd,
	output dlv_pkg::dlv_sts_t sts,
	input  logic signed [SAMPLE_WIDTH-1:0] cur_i,
	input  logic signed [SAMPLE_WIDTH-1:0] cur_q,
	output logic [ANGLE_WIDTH-1:0] phase,
	output logic [15:0] spread
);
	import dlv_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_PREP = 4'd1, S_NORM = 4'd2, S_CORD = 4'd3,
		S_SQ1 = 4'd4, S_SQ2 = 4'd5, S_SQ3 = 4'd6, S_SQRT = 4'd7, S_DIV = 4'd8,
		S_DONE = 4'd9;
	localparam int PW = 2 * SAMPLE_WIDTH + 1;

	logic signed [SAMPLE_WIDTH-1:0] prv_i_q, prv_q_q;
	logic signed [PW-1:0] m_a, m_b, m_c, m_d, m_e, m_f;
	logic [ACC_W-1:0] cross_q, real_q, power_q;
	logic [3:0] st_q;
	logic signed [49:0] x_q, y_q;
	logic [31:0] z_q;
	logic [4:0] it_q;
	logic [47:0] a_q, b_q, p_q;
	logic sp_fix_q;
	logic [15:0] sp_val_q;
	logic [63:0] s_q, rem_q, root_q;
	logic [5:0] sq_it_q;
	logic [47:0] num_q, dq_q;
	logic [5:0] dv_it_q;
	logic [63:0] sq_a_q;
	logic zero_q;
	logic signed [49:0] dx, dy, mx;
	logic [49:0] ay;
	logic [63:0] trial;
	logic [47:0] dvd, dnum;
	logic [48:0] dtrial;

	always_comb begin
		m_a = PW'(cur_q) * PW'(prv_i_q);
		m_b = PW'(prv_q_q) * PW'(cur_i);
		m_c = PW'(cur_i) * PW'(prv_i_q);
		m_d = PW'(cur_q) * PW'(prv_q_q);
		m_e = PW'(cur_i) * PW'(cur_i);
		m_f = PW'(cur_q) * PW'(cur_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_q <= '0;
			real_q <= '0;
			power_q <= '0;
			prv_i_q <= '0;
			prv_q_q <= '0;
		end else begin
			if (cmd.accum) begin
				cross_q <= cross_q + ACC_W'(m_a) - ACC_W'(m_b);
				real_q <= real_q + ACC_W'(m_c) + ACC_W'(m_d);
				power_q <= power_q + ACC_W'(m_e) + ACC_W'(m_f);
			end
			if (cmd.clear) begin
				cross_q <= '0;
				real_q <= '0;
				power_q <= '0;
			end
			if (cmd.take) begin
				prv_i_q <= cur_i;
				prv_q_q <= cur_q;
			end
		end
	end

	always_comb begin
		dx = x_q >>> it_q;
		dy = y_q >>> it_q;
		ay = y_q[49] ? 50'(-y_q) : 50'(y_q);
		mx = (50'(x_q) > ay) ? x_q : signed'(ay);
		trial = rem_q - (root_q + (64'd1 << {sq_it_q, 1'b0}));
		dvd = {root_q[32:0], 15'd0};
		dnum = {num_q[46:0], dvd[dv_it_q]};
		dtrial = {1'b0, dnum} - {1'b0, p_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			it_q <= '0;
			a_q <= '0;
			b_q <= '0;
			p_q <= '0;
			sp_fix_q <= 1'b0;
			sp_val_q <= '0;
			s_q <= '0;
			rem_q <= '0;
			root_q <= '0;
			sq_it_q <= '0;
			num_q <= '0;
			dq_q <= '0;
			dv_it_q <= '0;
			sq_a_q <= '0;
			zero_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (cmd.start) begin
					st_q <= S_PREP;
					x_q <= 50'(signed'(real_q));
					y_q <= 50'(signed'(cross_q));
					p_q <= power_q;
					a_q <= cross_q[47] ? 48'(-cross_q) : cross_q;
					b_q <= real_q[47] ? 48'(-real_q) : real_q;
					z_q <= '0;
					zero_q <= (cross_q == '0) && (real_q == '0);
				end
				S_PREP: begin
					if (x_q < 0) begin
						x_q <= -x_q;
						y_q <= -y_q;
						z_q <= 32'h8000_0000;
					end
					sp_fix_q <= 1'b1;
					if (p_q == '0) sp_val_q <= 16'hFFFF;
					else if (a_q >= p_q || b_q >= p_q) sp_val_q <= 16'd0;
					else sp_fix_q <= 1'b0;
					it_q <= '0;
					st_q <= S_NORM;
				end
				S_NORM: begin
					if (!zero_q && mx < (50'sd1 <<< 45)) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else if (!sp_fix_q && p_q >= (48'd1 << 30)) begin
						p_q <= p_q >> 1; a_q <= a_q >> 1; b_q <= b_q >> 1;
					end else if (!sp_fix_q && p_q < (48'd1 << 29)) begin
						p_q <= p_q << 1; a_q <= a_q << 1; b_q <= b_q << 1;
					end else begin
						st_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (!zero_q) begin
						if (!y_q[49]) begin
							x_q <= x_q + dy; y_q <= y_q - dx;
							z_q <= z_q + turn_angle(it_q);
						end else begin
							x_q <= x_q - dy; y_q <= y_q + dx;
							z_q <= z_q - turn_angle(it_q);
						end
					end
					it_q <= it_q + 5'd1;
					if (it_q == 5'(CORDIC_STEPS - 1)) st_q <= S_SQ1;
				end
				S_SQ1: begin
					sq_a_q <= 64'(a_q[29:0]) * 64'(a_q[29:0]);
					st_q <= S_SQ2;
				end
				S_SQ2: begin
					s_q <= sq_a_q;
					sq_a_q <= 64'(b_q[29:0]) * 64'(b_q[29:0]);
					st_q <= S_SQ3;
				end
				S_SQ3: begin
					s_q <= s_q + sq_a_q;
					sq_a_q <= 64'(p_q[29:0]) * 64'(p_q[29:0]);
					st_q <= S_SQRT;
					sq_it_q <= 6'd31;
					root_q <= '0;
					rem_q <= (s_q + sq_a_q) << 2;
				end
				S_SQRT: begin
					if (s_q >= sq_a_q && !sp_fix_q) begin
						sp_fix_q <= 1'b1;
						sp_val_q <= 16'd0;
					end
					if (!trial[63]) begin
						rem_q <= trial;
						root_q <= (root_q >> 1) + (64'd1 << {sq_it_q, 1'b0});
					end else begin
						root_q <= root_q >> 1;
					end
					sq_it_q <= sq_it_q - 6'd1;
					if (sq_it_q == 6'd0) begin
						st_q <= S_DIV;
						dv_it_q <= 6'd47;
						num_q <= '0;
						dq_q <= '0;
					end
				end
				S_DIV: begin
					if (!dtrial[48]) begin
						num_q <= dtrial[47:0];
						dq_q <= {dq_q[46:0], 1'b1};
					end else begin
						num_q <= dnum;
						dq_q <= {dq_q[46:0], 1'b0};
					end
					dv_it_q <= dv_it_q - 6'd1;
					if (dv_it_q == 6'd0) st_q <= S_DONE;
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	logic [31:0] zr;
	assign zr = z_q + (32'd1 << (31 - ANGLE_WIDTH));
	assign phase = zero_q ? '0 : zr[31 -: ANGLE_WIDTH];
	assign spread = sp_fix_q ? sp_val_q :
		((dq_q > 48'd65535) ? 16'd0 : 16'(16'hFFFF - dq_q[15:0]));
	assign sts.busy = (st_q != S_IDLE);
	assign sts.done = (st_q == S_DONE);
endmodule

[hdl/dlv_ctrl.sv]
// Controller: ensemble, depth and estimate counters, result handshake.
// Depends on dlv_pkg; commands dlv_datapath.
module dlv_ctrl #(
	parameter int MAX_ENSEMBLE = 32,
	parameter int MAX_PACKET = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [5:0] ens_size,
	input  logic [4:0] pkt_size,
	input  logic [12:0] line_size,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic last_flag,
	output dlv_pkg::dlv_cmd_t cmd,
	input  dlv_pkg::dlv_sts_t sts
);
	import dlv_pkg::*;

	logic [6:0] e_lim, p_lim;
	logic [12:0] l_lim;
	logic [5:0] ens_q;
	logic [6:0] dep_q;
	logic [11:0] est_q;
	logic pend_q, ovalid_q, last_q, acc;

	always_comb begin
		e_lim = (ens_size < 6'd2) ? 7'd2 :
			((7'(ens_size) > 7'(MAX_ENSEMBLE)) ? 7'(MAX_ENSEMBLE) : 7'(ens_size));
		p_lim = (pkt_size == '0) ? 7'd1 :
			((7'(pkt_size) > 7'(MAX_PACKET)) ? 7'(MAX_PACKET) : 7'(pkt_size));
		l_lim = (line_size == '0) ? 13'd1 : ((line_size > 13'd4096) ? 13'd4096 : line_size);
	end

	assign in_ready = !pend_q && !sts.busy && !ovalid_q;
	assign acc = in_valid && in_ready;
	assign cmd.take = acc;
	assign cmd.accum = acc && (ens_q != '0);
	assign cmd.start = pend_q && !sts.busy;
	assign cmd.clear = cmd.start;
	assign out_valid = ovalid_q;
	assign last_flag = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ens_q <= '0;
			dep_q <= '0;
			est_q <= '0;
			pend_q <= 1'b0;
			ovalid_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (acc) begin
				if (7'(ens_q) + 7'd1 < e_lim) begin
					ens_q <= ens_q + 6'd1;
				end else begin
					ens_q <= '0;
					if (dep_q + 7'd1 < p_lim) begin
						dep_q <= dep_q + 7'd1;
					end else begin
						dep_q <= '0;
						pend_q <= 1'b1;
					end
				end
			end
			if (cmd.start) begin
				pend_q <= 1'b0;
				last_q <= (13'(est_q) + 13'd1 >= l_lim);
				est_q <= (13'(est_q) + 13'd1 >= l_lim) ? '0 : est_q + 12'd1;
			end
			if (sts.done) ovalid_q <= 1'b1;
			else if (ovalid_q && out_ready) ovalid_q <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) ovalid_q |-> !acc)
		else $error("input taken while result held");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.start |=> sts.busy)
		else $error("finish unit did not start");
	assert property (@(posedge clk) disable iff (!arst_n) sts.done |-> !ovalid_q)
		else $error("result overwritten");
endmodule

[hdl/doppler_lag_one_velocity_estimator.sv]
// Top level of the lag-one velocity estimator: config registers, controller, datapath.
// Depends on dlv_pkg, dlv_ctrl and dlv_datapath.
//  channel   direction  handshake
//  sample    in         in_valid / in_ready
//  estimate  out        out_valid / out_ready
//  config    in         cfg_we (no wait)
// A sample is taken per cycle inside a packet; after the last sample of a packet
// the estimate goes through normalize, CORDIC, squares, root and divide before it is
// valid, and input stalls until the estimate is taken.
// Reset clears the sums, counters and registers to their defaults.
module doppler_lag_one_velocity_estimator #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int MAX_ENSEMBLE = 32,
	parameter int MAX_PACKET = 16,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [12:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] in_phase,
	input  logic signed [SAMPLE_WIDTH-1:0] quadrature,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [ANGLE_WIDTH-1:0] velocity_phase,
	output logic [15:0] spread,
	output logic last_of_line
);
	import dlv_pkg::*;

	localparam logic [1:0] R_ENS = 2'd0, R_PKT = 2'd1, R_LINE = 2'd2;

	logic [5:0] ens_q;
	logic [4:0] pkt_q;
	logic [12:0] line_q;
	dlv_cmd_t cmd;
	dlv_sts_t sts;
	logic [ANGLE_WIDTH-1:0] ph;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ens_q <= 6'd8;
			pkt_q <= 5'd1;
			line_q <= 13'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				R_ENS: ens_q <= cfg_data[5:0];
				R_PKT: pkt_q <= cfg_data[4:0];
				R_LINE: line_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dlv_ctrl #(.MAX_ENSEMBLE(MAX_ENSEMBLE), .MAX_PACKET(MAX_PACKET)) u_ctrl (
		.clk, .arst_n, .ens_size(ens_q), .pkt_size(pkt_q), .line_size(line_q),
		.in_valid, .in_ready, .out_valid, .out_ready, .last_flag(last_of_line),
		.cmd, .sts
	);

	dlv_datapath #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .sts, .cur_i(in_phase), .cur_q(quadrature),
		.phase(ph), .spread
	);

	assign velocity_phase = signed'(ph);
endmodule

[dv/dlv_tb_pkg.sv]
// Register indexes of the velocity estimator's configuration port.
// Shared by the testbench top and the estimate checker; no other dependencies.
package dlv_tb_pkg;
	typedef enum logic [1:0] {
		REG_ENSEMBLE = 2'd0,
		REG_PACKET   = 2'd1,
		REG_LINE     = 2'd2,
		REG_UNUSED   = 2'd3
	} dlv_reg_t;
endpackage

[dv/velocity_checker.sv]
// Estimate checker: watches config writes and both channels, predicts each estimate and compares.
// Depends on dlv_tb_pkg for the register indexes.
module velocity_checker
	import dlv_tb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [12:0] cfg_data,
	input  logic in_valid,
	input  logic in_ready,
	input  logic signed [15:0] in_phase,
	input  logic signed [15:0] quadrature,
	input  logic out_valid,
	input  logic out_ready,
	input  logic signed [15:0] velocity_phase,
	input  logic [15:0] spread,
	input  logic last_of_line,
	output int fails,
	output int pending,
	output int checked
);
	localparam logic [31:0] TURN [30] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	typedef struct {
		logic [15:0] angle;
		logic [15:0] spr;
		logic last;
	} estimate_t;

	estimate_t estimates_q[$];
	logic [5:0] ens_reg;
	logic [4:0] pkt_reg;
	logic [12:0] line_reg;
	longint prev_i, prev_q;
	logic [47:0] cross_acc, real_acc, power_acc;
	int ens_cnt, dep_cnt, est_cnt;

	function automatic logic [15:0] phase_est(longint y, longint x);
		logic [31:0] z;
		longint ay, m, dx, dy;
		z = 32'd0;
		if (x == 0 && y == 0)
			return 16'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		ay = (y < 0) ? -y : y;
		m = (x > ay) ? x : ay;
		while (m < (64'sd1 <<< 45)) begin
			x = x * 2;
			y = y * 2;
			m = m * 2;
		end
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + TURN[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - TURN[i];
			end
		end
		z = z + 32'h0000_8000;
		return z[31:16];
	endfunction

	function automatic logic [15:0] spread_est(longint c, longint r, logic [63:0] p);
		logic [63:0] a, b, s, f, v, root, probe;
		if (p == 0)
			return 16'hFFFF;
		a = (c < 0) ? -c : c;
		b = (r < 0) ? -r : r;
		if (a >= p || b >= p)
			return 16'd0;
		while (p >= (64'd1 << 30)) begin
			p = p >> 1;
			a = a >> 1;
			b = b >> 1;
		end
		while (p < (64'd1 << 29)) begin
			p = p << 1;
			a = a << 1;
			b = b << 1;
		end
		s = a * a + b * b;
		if (s >= p * p)
			return 16'd0;
		v = 4 * s;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v = v - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		f = (root << 15) / p;
		if (f > 65535)
			f = 65535;
		return 16'(65535 - f);
	endfunction

	task automatic report(string what);
		$display("mismatch at %0t: %s", $time, what);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		longint ci, cq, d, c, r;
		int e_lim, p_lim, l_lim;
		estimate_t est, got;
		if (!arst_n) begin
			ens_reg = 6'd8;
			pkt_reg = 5'd1;
			line_reg = 13'd256;
			prev_i = 0;
			prev_q = 0;
			cross_acc = '0;
			real_acc = '0;
			power_acc = '0;
			ens_cnt = 0;
			dep_cnt = 0;
			est_cnt = 0;
			estimates_q.delete();
			fails = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (dlv_reg_t'(cfg_index))
					REG_ENSEMBLE: ens_reg = cfg_data[5:0];
					REG_PACKET: pkt_reg = cfg_data[4:0];
					REG_LINE: line_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				ci = in_phase;
				cq = quadrature;
				e_lim = (ens_reg < 2) ? 2 : (ens_reg > 32) ? 32 : ens_reg;
				p_lim = (pkt_reg < 1) ? 1 : (pkt_reg > 16) ? 16 : pkt_reg;
				l_lim = (line_reg < 1) ? 1 : (line_reg > 4096) ? 4096 : line_reg;
				if (ens_cnt != 0) begin
					d = cq * prev_i - prev_q * ci;
					cross_acc = cross_acc + d[47:0];
					d = ci * prev_i + cq * prev_q;
					real_acc = real_acc + d[47:0];
					d = ci * ci + cq * cq;
					power_acc = power_acc + d[47:0];
				end
				prev_i = ci;
				prev_q = cq;
				if (ens_cnt + 1 < e_lim) begin
					ens_cnt++;
				end else begin
					ens_cnt = 0;
					if (dep_cnt + 1 < p_lim) begin
						dep_cnt++;
					end else begin
						dep_cnt = 0;
						c = longint'($signed(cross_acc));
						r = longint'($signed(real_acc));
						est.angle = phase_est(c, r);
						est.spr = spread_est(c, r, {16'd0, power_acc});
						est.last = (est_cnt + 1 >= l_lim);
						est_cnt = est.last ? 0 : est_cnt + 1;
						estimates_q.push_back(est);
						cross_acc = '0;
						real_acc = '0;
						power_acc = '0;
					end
				end
			end
			if (out_valid && out_ready) begin
				if (estimates_q.size() == 0) begin
					report("estimate with none expected");
				end else begin
					got = estimates_q.pop_front();
					checked++;
					if (velocity_phase !== got.angle)
						report($sformatf("velocity_phase %0d, want %0d",
							velocity_phase, $signed(got.angle)));
					if (spread !== got.spr)
						report($sformatf("spread %0d, want %0d", spread, got.spr));
					if (last_of_line !== got.last)
						report($sformatf("last_of_line %b, want %b", last_of_line, got.last));
				end
			end
			pending = estimates_q.size();
		end
	end
endmodule

[dv/tb.sv]
// Testbench top for the lag-one velocity estimator: clock, reset, config writes and sample stimulus.
// Depends on dlv_tb_pkg, velocity_checker and the estimator RTL.
module tb;
	import dlv_tb_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int SETTLE = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [12:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] in_phase = '0;
	logic signed [15:0] quadrature = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] velocity_phase;
	logic [15:0] spread;
	logic last_of_line;
	int fails, pending, checked;
	int sender_idle = 0;
	int recv_stall = 0;
	int idle_cycles = 0;
	int sent = 0;
	int settings = 0;
	int e_eff = 8;
	int p_eff = 1;

	always #2 clk = ~clk;

	doppler_lag_one_velocity_estimator u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_phase(in_phase), .quadrature(quadrature), .out_valid(out_valid),
		.out_ready(out_ready), .velocity_phase(velocity_phase), .spread(spread),
		.last_of_line(last_of_line)
	);

	velocity_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_phase(in_phase), .quadrature(quadrature), .out_valid(out_valid),
		.out_ready(out_ready), .velocity_phase(velocity_phase), .spread(spread),
		.last_of_line(last_of_line), .fails(fails), .pending(pending), .checked(checked)
	);

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_word(logic [15:0] i_val, logic [15:0] q_val);
		while ($urandom_range(99) < sender_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_phase <= i_val;
		quadrature <= q_val;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
	endtask

	task automatic write_reg(dlv_reg_t idx, logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// drain all estimates, then let the finish unit settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(int e, int p, int l);
		write_reg(REG_ENSEMBLE, 13'(e));
		write_reg(REG_PACKET, 13'(p));
		write_reg(REG_LINE, 13'(l));
		e_eff = (e[5:0] < 2) ? 2 : (e[5:0] > 32) ? 32 : e[5:0];
		p_eff = (p[4:0] < 1) ? 1 : (p[4:0] > 16) ? 16 : p[4:0];
		settings++;
	endtask

	function automatic logic [15:0] sat16(real v);
		if (v > 32767.0)
			return 16'h7FFF;
		if (v < -32768.0)
			return 16'h8000;
		return 16'($rtoi(v));
	endfunction

	function automatic logic [15:0] edge_value();
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'hFFFF;
			2: return 16'h0000;
			3: return 16'h0001;
			default: return 16'h7FFF;
		endcase
	endfunction

	task automatic send_block(int n);
		int kind, amp;
		real th, step;
		kind = $urandom_range(99);
		amp = $urandom_range(1, 30000);
		th = $urandom_range(6283) / 1000.0;
		step = ($itor($urandom_range(6283)) - 3141.0) / 1000.0;
		for (int k = 0; k < n; k++) begin
			if (k % e_eff == 0 && $urandom_range(3) == 0) begin
				kind = $urandom_range(99);
				amp = $urandom_range(1, 30000);
			end
			if (kind < 70)
				send_word(sat16(amp * $cos(th) + $itor($urandom_range(400)) - 200.0),
					sat16(amp * $sin(th) + $itor($urandom_range(400)) - 200.0));
			else if (kind < 85)
				send_word(16'($urandom), 16'($urandom));
			else
				send_word(edge_value(), edge_value());
			th = th + step;
		end
	endtask

	initial begin
		int e, p, l, n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(2, 1, 3);
		write_reg(REG_UNUSED, 13'h1FFF);
		send_word(16'h0000, 16'h0000);
		send_word(16'h0000, 16'h0000);
		send_word(16'd1000, 16'h0000);
		send_word(-16'sd1000, 16'h0000);
		send_word(16'h7FFF, 16'h7FFF);
		send_word(16'h8000, 16'h8000);
		send_word(16'h8000, 16'h0000);
		send_word(16'h0000, 16'h7FFF);
		send_word(16'h0000, 16'h8000);
		send_word(16'h7FFF, 16'h0000);
		send_word(16'h7FFF, 16'h8000);
		send_word(16'h8000, 16'h7FFF);
		send_word(16'h5555, 16'hAAAA);
		send_word(16'hAAAA, 16'h5555);
		send_word(16'h0001, 16'hFFFF);
		send_word(16'hFFFF, 16'h0001);
		drain();

		for (int ph = 0; sent < 630; ph++) begin
			case (ph % 4)
				0: begin sender_idle = 0; recv_stall = 0; end
				1: begin sender_idle = 62; recv_stall = 0; end
				2: begin sender_idle = 0; recv_stall = 62; end
				default: begin sender_idle = 9; recv_stall = 9; end
			endcase
			case (ph)
				0: begin e = 0; p = 0; l = 0; end
				1: begin e = 63; p = 31; l = 8191; end
				2: begin e = 32; p = 1; l = 4096; end
				3: begin e = 2; p = 16; l = 1; end
				4: begin e = 33; p = 17; l = 4097; end
				5: begin e = 1; p = 2; l = 2; end
				default: begin
					e = $urandom_range(2, 8);
					p = $urandom_range(1, 3);
					l = $urandom_range(1, 4);
				end
			endcase
			configure(e, p, l);
			n = e_eff * p_eff * $urandom_range(1, 4) + $urandom_range(0, 2);
			if (n > 80)
				n = 80;
			send_block(n);
			drain();
		end

		$display("sent %0d samples over %0d register settings, checked %0d estimates",
			sent, settings, checked);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

[doppler_lag_one_velocity_estimator.f]
hdl/dlv_pkg.sv
hdl/dlv_datapath.sv
hdl/dlv_ctrl.sv
hdl/doppler_lag_one_velocity_estimator.sv
dv/dlv_tb_pkg.sv
dv/velocity_checker.sv
dv/tb.sv
